/* design/gha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg: shared types and constants
// Command codes, controller states, the controller-to-datapath command
// struct and the fixed field widths of the allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int GHA_SLOT_COUNT      = 1024;
   localparam int GHA_GENERATION_BITS = 16;

   localparam int CMD_W     = 2;
   localparam int IDX_IO_W  = 10;
   localparam int GEN_IO_W  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_CHECK   = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;   // latch request, launch slot memory read
      logic execute;   // update slot memories, load result register
   } ctrl_cmd_type;

endpackage

/* design/gha_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_req_if: request channel
// Valid/ready channel carrying one allocator command with its handle.
// ----------------------------------------------------------------------------
interface gha_req_if import gha_pkg::*;;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [IDX_IO_W-1:0] slot_index;
   logic [GEN_IO_W-1:0] slot_generation;

   modport source (output valid, output command, output slot_index,
                   output slot_generation, input ready);
   modport sink   (input valid, input command, input slot_index,
                   input slot_generation, output ready);

endinterface

/* design/gha_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_rsp_if: response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface gha_rsp_if import gha_pkg::*;;

   logic                valid;
   logic                ready;
   logic [IDX_IO_W-1:0] handle_index;
   logic [GEN_IO_W-1:0] handle_generation;
   logic                success;
   logic                table_full;

   modport source (output valid, output handle_index, output handle_generation,
                   output success, output table_full, input ready);
   modport sink   (input valid, input handle_index, input handle_generation,
                   input success, input table_full, output ready);

endinterface

/* design/generational_handle_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot allocator with generation-checked handles
// Create, destroy and check of (index, generation) handles over a slot table
// with a LIFO free list; slot zero is reserved.
// ----------------------------------------------------------------------------
// A request is captured and its slot memories read; the block then updates
// the slot memories and loads the result into the output register, waiting
// first while the previous result is still uncollected. The read-modify-write
// of the slot memories (one registered read, then one write) allows only one
// request in flight. A new request is taken while the previous result still
// waits to be collected. No clearing pass runs after reset: slots at and above
// the high-water count read as fresh, so requests are taken right after reset.
// ----------------------------------------------------------------------------
module generational_handle_allocator import gha_pkg::*; #(
   parameter int SLOT_COUNT      = GHA_SLOT_COUNT,
   parameter int GENERATION_BITS = GHA_GENERATION_BITS
) (
   input  logic     clock,
   input  logic     reset,
   gha_req_if.sink   req_ch,
   gha_rsp_if.source rsp_ch
);

   ctrl_cmd_type dp_cmd;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (dp_cmd)
   );

   gha_datapath #(
      .SLOT_COUNT      (SLOT_COUNT),
      .GENERATION_BITS (GENERATION_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (dp_cmd),
      .req_command           (req_ch.command),
      .req_slot_index        (req_ch.slot_index),
      .req_slot_generation   (req_ch.slot_generation),
      .rsp_handle_index      (rsp_ch.handle_index),
      .rsp_handle_generation (rsp_ch.handle_generation),
      .rsp_success           (rsp_ch.success),
      .rsp_table_full        (rsp_ch.table_full)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while previous one still in flight");

   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute |-> ($past(dp_cmd.capture) || $past(dp_cmd.execute) ||
                          $past(!req_ch.ready)))
      else $error("execute without a captured request");

   a_exec_fills_output: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.execute |=> rsp_ch.valid)
      else $error("executed request produced no response");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.table_full) |->
         (!rsp_ch.success && rsp_ch.handle_generation == '0))
      else $error("table full response reports a handle");

endmodule

/* design/gha_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gha_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_ctrl: allocator controller
// Two-state sequencer: take a request and read, then update and respond.
// Owns the response valid flag.
// ----------------------------------------------------------------------------
module gha_ctrl import gha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign out_valid_in = cmd.execute || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

/* design/gha_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_datapath: allocator datapath
// Slot memories (generation with alive mark, free-list link), free-list
// head, high-water count and the result register.
// ----------------------------------------------------------------------------
module gha_datapath import gha_pkg::*; #(
   parameter int SLOT_COUNT      = GHA_SLOT_COUNT,
   parameter int GENERATION_BITS = GHA_GENERATION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [IDX_IO_W-1:0] req_slot_index,
   input  logic [GEN_IO_W-1:0] req_slot_generation,
   output logic [IDX_IO_W-1:0] rsp_handle_index,
   output logic [GEN_IO_W-1:0] rsp_handle_generation,
   output logic                rsp_success,
   output logic                rsp_table_full
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int CMPI_W = (CNT_W > IDX_IO_W) ? CNT_W : IDX_IO_W;
   localparam int CMPG_W = (GENERATION_BITS > GEN_IO_W) ? GENERATION_BITS : GEN_IO_W;
   localparam int GA_W   = GENERATION_BITS + 1;
   localparam int LNK_W  = IDX_W + 1;

   logic [CMD_W-1:0]    cmd_ff;
   logic [IDX_IO_W-1:0] idx_ff;
   logic [GEN_IO_W-1:0] gin_ff;

   logic [IDX_W-1:0] head_ff, head_in;
   logic             nonempty_ff, nonempty_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [IDX_IO_W-1:0] out_idx_ff, out_idx_in;
   logic [GEN_IO_W-1:0] out_gen_ff, out_gen_in;
   logic                out_ok_ff, out_ok_in;
   logic                out_full_ff, out_full_in;

   logic [IDX_W-1:0]           alloc_slot, idx_addr, rd_addr, ga_wr_addr;
   logic [GA_W-1:0]            ga_rd, ga_wr_data;
   logic [LNK_W-1:0]           lnk_rd;
   logic                       ga_wr_en, lnk_wr_en;
   logic [GENERATION_BITS-1:0] new_gen;
   logic                       in_range, full;

   // next slot to hand out: top of the free list, else the first fresh slot
   assign alloc_slot = nonempty_ff ? head_ff : IDX_W'(count_ff);
   assign rd_addr    = (req_command == CMD_CREATE) ? alloc_slot : IDX_W'(req_slot_index);
   assign idx_addr   = IDX_W'(idx_ff);

   // slot zero is reserved and never written
   assign in_range = (idx_ff != '0) && (CMPI_W'(idx_ff) < CMPI_W'(count_ff));
   assign full     = !nonempty_ff && (count_ff == CNT_W'(SLOT_COUNT));
   // fresh slots sit at and above the count; their generation counts from zero
   assign new_gen  = (nonempty_ff ? ga_rd[GENERATION_BITS-1:0] : '0) + 1'b1;

   gha_ram #(.WIDTH(GA_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
      .clock   (clock),
      .wr_en   (ga_wr_en),
      .wr_addr (ga_wr_addr),
      .wr_data (ga_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (ga_rd)
   );

   gha_ram #(.WIDTH(LNK_W), .DEPTH(SLOT_COUNT)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_wr_en),
      .wr_addr (idx_addr),
      .wr_data ({nonempty_ff, head_ff}),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (lnk_rd)
   );

   always_comb begin
      ga_wr_en    = 1'b0;
      lnk_wr_en   = 1'b0;
      ga_wr_addr  = idx_addr;
      ga_wr_data  = {1'b0, ga_rd[GENERATION_BITS-1:0]};
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      count_in    = count_ff;
      out_idx_in  = idx_ff;
      out_gen_in  = '0;
      out_ok_in   = 1'b0;
      out_full_in = 1'b0;
      case (cmd_ff)
         CMD_CREATE: begin
            if (full) begin
               out_full_in = 1'b1;
            end else begin
               ga_wr_en   = cmd.execute;
               ga_wr_addr = alloc_slot;
               ga_wr_data = {1'b1, new_gen};
               if (nonempty_ff) begin
                  head_in     = lnk_rd[IDX_W-1:0];
                  nonempty_in = lnk_rd[IDX_W];
               end else begin
                  count_in = count_ff + 1'b1;
               end
               out_idx_in = IDX_IO_W'(alloc_slot);
               out_gen_in = GEN_IO_W'(new_gen);
               out_ok_in  = 1'b1;
            end
         end
         CMD_DESTROY: begin
            if (in_range && ga_rd[GENERATION_BITS]) begin
               ga_wr_en    = cmd.execute;
               lnk_wr_en   = cmd.execute;
               head_in     = idx_addr;
               nonempty_in = 1'b1;
               out_ok_in   = 1'b1;
            end
         end
         CMD_CHECK: begin
            out_ok_in = in_range && ga_rd[GENERATION_BITS] &&
                        (CMPG_W'(ga_rd[GENERATION_BITS-1:0]) == CMPG_W'(gin_ff));
         end
         default: begin
            out_ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         count_ff    <= CNT_W'(1);
      end else if (cmd.execute) begin
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         idx_ff <= req_slot_index;
         gin_ff <= req_slot_generation;
      end
      if (cmd.execute) begin
         out_idx_ff  <= out_idx_in;
         out_gen_ff  <= out_gen_in;
         out_ok_ff   <= out_ok_in;
         out_full_ff <= out_full_in;
      end
   end

   assign rsp_handle_index      = out_idx_ff;
   assign rsp_handle_generation = out_gen_ff;
   assign rsp_success           = out_ok_ff;
   assign rsp_table_full        = out_full_ff;

endmodule
